FILE: hw/rtl/bfpa_pkg.sv
// Shared types and constants for the best-fit partition allocator.
`timescale 1ns / 1ps

package bfpa_pkg;

    localparam int CMD_W   = 1;
    localparam int IDX_W   = 4;
    localparam int SIZE_W  = 16;
    localparam int COUNT_W = 5;

    // wide enough for any cell index or count used in compares
    localparam int CMP_W   = 9;
    // staging width for size conversions between port and storage widths
    localparam int STAGE_W = 48;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

endpackage

FILE: hw/rtl/bfpa_if.sv
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps

interface bfpa_in_if;
    import bfpa_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [IDX_W-1:0]   block_index;
    logic [SIZE_W-1:0]  size_value;
    logic               last_request;

    modport source (
        output valid, command, block_index, size_value, last_request,
        input  ready
    );
    modport sink (
        input  valid, command, block_index, size_value, last_request,
        output ready
    );
endinterface

interface bfpa_out_if;
    import bfpa_pkg::*;

    logic               valid;
    logic               ready;
    logic               granted;
    logic [IDX_W-1:0]   chosen_block;
    logic [SIZE_W-1:0]  space_left;
    logic               batch_done;

    modport source (
        output valid, granted, chosen_block, space_left, batch_done,
        input  ready
    );
    modport sink (
        input  valid, granted, chosen_block, space_left, batch_done,
        output ready
    );
endinterface

FILE: hw/rtl/bfpa_cell.sv
// One partition cell: holds a free-space entry and merges it into the passing best-fit token.
`timescale 1ns / 1ps

module bfpa_cell #(
    parameter int CELL_IDX  = 0,
    parameter int IDX_BITS  = 4,
    parameter int SIZE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bfpa_pkg::COUNT_W-1:0]  i_limit,
    input  logic [SIZE_BITS-1:0]          i_size,
    input  logic                          i_wr_en,
    input  logic [IDX_BITS-1:0]           i_wr_idx,
    input  logic [SIZE_BITS-1:0]          i_wr_data,
    input  logic                          i_found,
    input  logic [IDX_BITS-1:0]           i_best_idx,
    input  logic [SIZE_BITS-1:0]          i_best_val,
    output logic                          o_found,
    output logic [IDX_BITS-1:0]           o_best_idx,
    output logic [SIZE_BITS-1:0]          o_best_val
);
    import bfpa_pkg::*;

    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_IDX);

    logic [SIZE_BITS-1:0] r_value;
    logic                 r_found;
    logic [IDX_BITS-1:0]  r_best_idx;
    logic [SIZE_BITS-1:0] r_best_val;

    logic in_range;
    logic fits;
    logic take;

    assign in_range = CMP_W'(CELL_IDX) < CMP_W'(i_limit);
    assign fits     = in_range && (r_value >= i_size);
    // strict less-than keeps the lower index on a tie
    assign take     = fits && (!i_found || (r_value < i_best_val));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
        end else if (i_wr_en && (i_wr_idx == MY_IDX)) begin
            r_value <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else begin
            r_found <= i_found || take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best_idx <= take ? MY_IDX  : i_best_idx;
        r_best_val <= take ? r_value : i_best_val;
    end

    assign o_found    = r_found;
    assign o_best_idx = r_best_idx;
    assign o_best_val = r_best_val;

endmodule

FILE: hw/rtl/bfpa_ctrl.sv
// Sequencer: takes requests, times the scan of the cell chain, writes back and holds the result.
`timescale 1ns / 1ps

module bfpa_ctrl #(
    parameter int NUM_BLOCKS = 16,
    parameter int IDX_BITS   = 4,
    parameter int SIZE_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bfpa_in_if.sink               i_in,
    bfpa_out_if.source            o_out,
    output logic [SIZE_BITS-1:0]  o_size,
    output logic                  o_wr_en,
    output logic [IDX_BITS-1:0]   o_wr_idx,
    output logic [SIZE_BITS-1:0]  o_wr_data,
    input  logic                  i_found,
    input  logic [IDX_BITS-1:0]   i_best_idx,
    input  logic [SIZE_BITS-1:0]  i_best_val
);
    import bfpa_pkg::*;

    localparam int CNT_BITS = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(NUM_BLOCKS - 1);

    t_state r_state, n_state;
    logic [CNT_BITS-1:0]  r_cnt, n_cnt;
    logic [CMD_W-1:0]     r_cmd;
    logic [IDX_W-1:0]     r_idx;
    logic [SIZE_BITS-1:0] r_size;
    logic                 r_last;

    logic                 r_out_valid, n_out_valid;
    logic                 r_out_granted, n_out_granted;
    logic [IDX_W-1:0]     r_out_chosen, n_out_chosen;
    logic [SIZE_W-1:0]    r_out_left, n_out_left;

    logic                 in_xfer;
    logic                 out_free;
    logic                 finish;
    logic                 load_ok;
    logic [SIZE_BITS-1:0] new_val;
    logic [STAGE_W-1:0]   size_stage;
    logic [STAGE_W-1:0]   req_stage;
    logic [STAGE_W-1:0]   new_stage;
    logic [CMP_W-1:0]     idx_wide;
    logic [CMP_W-1:0]     best_wide;

    assign in_xfer   = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign finish    = (r_state == ST_UPDATE) && out_free;

    assign size_stage = STAGE_W'(i_in.size_value);
    assign req_stage  = STAGE_W'(r_size);
    assign idx_wide   = CMP_W'(r_idx);
    assign best_wide  = CMP_W'(i_best_idx);
    assign load_ok    = idx_wide < CMP_W'(NUM_BLOCKS);
    assign new_val    = i_best_val - r_size;
    assign new_stage  = STAGE_W'(new_val);

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (in_xfer) begin
                    n_state = (i_in.command == CMD_ALLOC) ? ST_SCAN : ST_UPDATE;
                end
            end
            ST_SCAN: begin
                n_cnt = r_cnt + 1'b1;
                // last cell's token has settled once every cell has been clocked
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        i_in.ready    = (r_state == ST_IDLE);
        o_wr_en       = 1'b0;
        o_wr_idx      = '0;
        o_wr_data     = '0;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_granted = r_out_granted;
        n_out_chosen  = r_out_chosen;
        n_out_left    = r_out_left;
        if (finish) begin
            n_out_valid = 1'b1;
            if (r_cmd == CMD_LOAD) begin
                o_wr_en       = load_ok;
                o_wr_idx      = idx_wide[IDX_BITS-1:0];
                o_wr_data     = r_size;
                n_out_granted = 1'b0;
                n_out_chosen  = r_idx;
                n_out_left    = load_ok ? req_stage[SIZE_W-1:0] : '0;
            end else if (i_found) begin
                o_wr_en       = 1'b1;
                o_wr_idx      = i_best_idx;
                o_wr_data     = new_val;
                n_out_granted = 1'b1;
                n_out_chosen  = best_wide[IDX_W-1:0];
                n_out_left    = new_stage[SIZE_W-1:0];
            end else begin
                n_out_granted = 1'b0;
                n_out_chosen  = '0;
                n_out_left    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd  <= i_in.command;
            r_idx  <= i_in.block_index;
            r_size <= size_stage[SIZE_BITS-1:0];
            r_last <= i_in.last_request;
        end
        r_out_granted <= n_out_granted;
        r_out_chosen  <= n_out_chosen;
        r_out_left    <= n_out_left;
    end

    logic r_out_last;
    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_last <= r_last;
        end
    end

    assign o_size             = r_size;
    assign o_out.valid        = r_out_valid;
    assign o_out.granted      = r_out_granted;
    assign o_out.chosen_block = r_out_chosen;
    assign o_out.space_left   = r_out_left;
    assign o_out.batch_done   = r_out_last;

endmodule

FILE: hw/rtl/best_fit_partition_allocator_top.sv
// Top level of the best-fit partition allocator: cell chain, sequencer and count register.
//
// Usage:
//   i_in  carries one command per transfer: load (block_index, size_value) or
//         allocate (size_value). last_request is echoed as batch_done.
//   o_out returns exactly one result per command: granted, chosen_block,
//         space_left, batch_done.
//   i_cfg_wr_en / i_cfg_wr_data write block_count (partitions 0..count-1 take
//         part); write it only while no command is in flight.
// Sequence and throughput:
//   A load goes straight to write-back. For an allocation the best-fit token
//   first walks the row of cells one cell per cycle, then the winner is written
//   back; either write-back waits until the output register is free.
//   One command is processed at a time; the next is taken once the current
//   one has been written into the output register.
// Reset: every partition reads zero free space and block_count is 16.
// Stall: a result waits in the output register; a new command is still taken,
//   and its write-back waits until the held result has been transferred.
`timescale 1ns / 1ps

module best_fit_partition_allocator_top #(
    parameter int NUM_BLOCKS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bfpa_in_if.sink                       i_in,
    bfpa_out_if.source                    o_out,
    input  logic                          i_cfg_wr_en,
    input  logic [bfpa_pkg::COUNT_W-1:0]  i_cfg_wr_data
);
    import bfpa_pkg::*;

    localparam int IDX_BITS = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    logic [COUNT_W-1:0]   r_block_count;
    logic [SIZE_BITS-1:0] size;
    logic                 wr_en;
    logic [IDX_BITS-1:0]  wr_idx;
    logic [SIZE_BITS-1:0] wr_data;

    logic                 tok_found [NUM_BLOCKS+1];
    logic [IDX_BITS-1:0]  tok_idx   [NUM_BLOCKS+1];
    logic [SIZE_BITS-1:0] tok_val   [NUM_BLOCKS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= COUNT_RESET;
        end else if (i_cfg_wr_en) begin
            r_block_count <= i_cfg_wr_data;
        end
    end

    // empty token enters the head of the chain
    assign tok_found[0] = 1'b0;
    assign tok_idx[0]   = '0;
    assign tok_val[0]   = '0;

    for (genvar g = 0; g < NUM_BLOCKS; g++) begin : g_cell
        bfpa_cell #(
            .CELL_IDX  (g),
            .IDX_BITS  (IDX_BITS),
            .SIZE_BITS (SIZE_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_limit    (r_block_count),
            .i_size     (size),
            .i_wr_en    (wr_en),
            .i_wr_idx   (wr_idx),
            .i_wr_data  (wr_data),
            .i_found    (tok_found[g]),
            .i_best_idx (tok_idx[g]),
            .i_best_val (tok_val[g]),
            .o_found    (tok_found[g+1]),
            .o_best_idx (tok_idx[g+1]),
            .o_best_val (tok_val[g+1])
        );
    end

    bfpa_ctrl #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .IDX_BITS   (IDX_BITS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_out      (o_out),
        .o_size     (size),
        .o_wr_en    (wr_en),
        .o_wr_idx   (wr_idx),
        .o_wr_data  (wr_data),
        .i_found    (tok_found[NUM_BLOCKS]),
        .i_best_idx (tok_idx[NUM_BLOCKS]),
        .i_best_val (tok_val[NUM_BLOCKS])
    );

endmodule

FILE: verif/best_fit_partition_allocator_top_tb.sv
// Testbench for best_fit_partition_allocator_top: random load/allocate traffic, best-fit check.
`timescale 1ns / 1ps

module best_fit_partition_allocator_top_tb;
    import bfpa_pkg::*;

    localparam int NUM_PARTS = 16;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [IDX_W-1:0]  block_index;
        logic [SIZE_W-1:0] size_value;
        logic              last_request;
    } t_req;

    typedef struct packed {
        logic              granted;
        logic [IDX_W-1:0]  chosen_block;
        logic [SIZE_W-1:0] space_left;
        logic              batch_done;
    } t_grant;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_wr_en;
    logic [COUNT_W-1:0] i_cfg_wr_data;

    bfpa_in_if  in_if ();
    bfpa_out_if out_if ();

    best_fit_partition_allocator_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_if),
        .o_out         (out_if),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // model state
    logic [SIZE_W-1:0]  free_left [NUM_PARTS];
    logic [COUNT_W-1:0] alloc_limit;

    t_req   req_q [$];
    t_grant grant_q [$];
    int     items_issued = 0;
    int     results_seen = 0;
    int     err_count = 0;
    int     send_gap = 0;
    int     stall_left = 0;
    logic   in_took = 1'b0;
    logic   calm = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        in_if.valid = 1'b0;
        in_if.command = CMD_LOAD;
        in_if.block_index = '0;
        in_if.size_value = '0;
        in_if.last_request = 1'b0;
        out_if.ready = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // best fit: least free space that still fits, lowest index on a tie
    function automatic t_grant apply_request(t_req r);
        t_grant g;
        int     lim;
        int     best;
        logic   found;
        g = '0;
        g.batch_done = r.last_request;
        if (r.command == CMD_LOAD) begin
            free_left[r.block_index] = r.size_value;
            g.chosen_block = r.block_index;
            g.space_left = r.size_value;
        end else begin
            lim = (alloc_limit > NUM_PARTS) ? NUM_PARTS : int'(alloc_limit);
            found = 1'b0;
            best = 0;
            for (int j = 0; j < lim; j++) begin
                if (free_left[j] >= r.size_value &&
                    (!found || free_left[j] < free_left[best])) begin
                    best = j;
                    found = 1'b1;
                end
            end
            if (found) begin
                free_left[best] = free_left[best] - r.size_value;
                g.granted = 1'b1;
                g.chosen_block = best[IDX_W-1:0];
                g.space_left = free_left[best];
            end
        end
        return g;
    endfunction

    task automatic report_mismatch(input string what, input t_grant got, input t_grant want);
        err_count++;
        $display("%0t ERROR %s: got %0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d",
                 $time, what, got.granted, got.chosen_block, got.space_left,
                 got.batch_done, want.granted, want.chosen_block, want.space_left,
                 want.batch_done);
    endtask

    // predictor and result checker
    always @(posedge i_clk) begin
        t_req   r;
        t_grant got;
        t_grant want;
        in_took <= in_if.valid && in_if.ready;
        if (!i_rst_n) begin
            for (int j = 0; j < NUM_PARTS; j++)
                free_left[j] = '0;
            alloc_limit = COUNT_RESET;
        end else begin
            if (i_cfg_wr_en)
                alloc_limit = i_cfg_wr_data;
            if (in_if.valid && in_if.ready) begin
                r.command = in_if.command;
                r.block_index = in_if.block_index;
                r.size_value = in_if.size_value;
                r.last_request = in_if.last_request;
                grant_q.push_back(apply_request(r));
            end
            if (out_if.valid && out_if.ready) begin
                got.granted = out_if.granted;
                got.chosen_block = out_if.chosen_block;
                got.space_left = out_if.space_left;
                got.batch_done = out_if.batch_done;
                results_seen++;
                if (grant_q.size() == 0) begin
                    report_mismatch("unexpected result", got, '0);
                end else begin
                    want = grant_q.pop_front();
                    if (got !== want)
                        report_mismatch("result mismatch", got, want);
                end
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        t_req r;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_took) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                in_if.valid <= 1'b0;
            end else if (req_q.size() > 0) begin
                r = req_q.pop_front();
                in_if.command <= r.command;
                in_if.block_index <= r.block_index;
                in_if.size_value <= r.size_value;
                in_if.last_request <= r.last_request;
                in_if.valid <= 1'b1;
                send_gap = pick_gap();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    task automatic queue_req(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                             input logic [SIZE_W-1:0] sz, input logic last);
        t_req r;
        r.command = cmd;
        r.block_index = idx;
        r.size_value = sz;
        r.last_request = last;
        req_q.push_back(r);
        items_issued++;
    endtask

    task automatic wait_drained();
        while (results_seen != items_issued)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] v);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic queue_random(input int n);
        int                r;
        logic [IDX_W-1:0]  idx;
        logic [SIZE_W-1:0] sz;
        logic              last;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            idx = IDX_W'($urandom_range(0, NUM_PARTS - 1));
            last = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 99) < 40) begin
                if (r < 30)      sz = SIZE_W'($urandom_range(0, 65535));
                else if (r < 60) sz = SIZE_W'($urandom_range(0, 1023));
                else if (r < 80) sz = SIZE_W'(100 * $urandom_range(1, 4));   // ties
                else if (r < 90) sz = 16'hFFFF;
                else             sz = '0;
                queue_req(CMD_LOAD, idx, sz, last);
            end else begin
                if (r < 45)      sz = SIZE_W'($urandom_range(0, 255));
                else if (r < 65) sz = SIZE_W'($urandom_range(0, 65535));
                else if (r < 80) sz = SIZE_W'(100 * $urandom_range(0, 4));
                else if (r < 90) sz = '0;
                else if (r < 95) sz = 16'hFFFF;
                else             sz = SIZE_W'($urandom_range(60000, 65535));
                queue_req(CMD_ALLOC, idx, sz, last);
            end
        end
    endtask

    initial begin
        logic [COUNT_W-1:0] counts [8];
        counts = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd17, 5'd8, 5'd15, 5'd2};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table at reset: zero-size request still fits partition 0
        queue_req(CMD_ALLOC, 4'd15, 16'd0, 1'b0);
        queue_req(CMD_ALLOC, 4'd0, 16'd1, 1'b0);
        queue_req(CMD_LOAD, 4'd0, 16'd500, 1'b0);
        queue_req(CMD_LOAD, 4'd15, 16'hFFFF, 1'b0);
        queue_req(CMD_LOAD, 4'd7, 16'd300, 1'b0);
        queue_req(CMD_LOAD, 4'd3, 16'd300, 1'b0);
        queue_req(CMD_ALLOC, 4'd0, 16'd300, 1'b0);     // tie -> lower index
        queue_req(CMD_ALLOC, 4'd0, 16'd300, 1'b0);
        queue_req(CMD_ALLOC, 4'd0, 16'd0, 1'b0);
        queue_req(CMD_ALLOC, 4'd0, 16'hFFFF, 1'b0);
        queue_req(CMD_ALLOC, 4'd0, 16'd501, 1'b0);     // no fit
        queue_req(CMD_ALLOC, 4'd0, 16'd200, 1'b1);
        queue_req(CMD_LOAD, 4'd9, 16'd0, 1'b1);
        queue_req(CMD_LOAD, 4'd10, 16'hAAAA, 1'b0);
        queue_req(CMD_LOAD, 4'd5, 16'h5555, 1'b0);
        queue_req(CMD_ALLOC, 4'd0, 16'h5555, 1'b0);
        queue_req(CMD_ALLOC, 4'd0, 16'h8000, 1'b0);
        queue_req(CMD_LOAD, 4'd15, 16'hFFFF, 1'b0);
        queue_req(CMD_ALLOC, 4'd0, 16'd1, 1'b1);
        wait_drained();

        // zero count grants nothing
        write_count(5'd0);
        queue_req(CMD_ALLOC, 4'd0, 16'd0, 1'b0);
        queue_req(CMD_ALLOC, 4'd0, 16'd1, 1'b1);
        wait_drained();
        // count above table size acts as full table
        write_count(5'd31);
        queue_req(CMD_ALLOC, 4'd0, 16'hFFFF, 1'b0);
        wait_drained();
        write_count(5'd1);
        queue_req(CMD_ALLOC, 4'd0, 16'd1, 1'b0);
        queue_req(CMD_ALLOC, 4'd0, 16'd1000, 1'b1);
        wait_drained();

        foreach (counts[p]) begin
            write_count(counts[p]);
            calm = (p == 4);
            queue_random(240);
            wait_drained();
        end

        repeat (20) @(negedge i_clk);
        if (err_count == 0)
            $display("best_fit_partition_allocator_top_tb: done, clean");
        else
            $display("best_fit_partition_allocator_top_tb: done, errors");
        $finish;
    end

    initial begin
        #12_000_000;
        $display("best_fit_partition_allocator_top_tb: done, errors");
        $finish;
    end

endmodule
